>>> design/svq_pkg.sv
package svq_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int COORD_BITS_DEFAULT  = 10;

   localparam int ACTION_W = 2;
   localparam int MASK_W   = 6;
   localparam int STEP_W   = 3;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SIDES  = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_CENTER = 3'd0;
   localparam step_type STEP_Y_UP   = 3'd1;
   localparam step_type STEP_Z_UP   = 3'd2;
   localparam step_type STEP_X_UP   = 3'd3;
   localparam step_type STEP_X_DOWN = 3'd4;
   localparam step_type STEP_Z_DOWN = 3'd5;
   localparam step_type STEP_Y_DOWN = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_PROBE,
      ST_COMPARE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_FINISH
   } state_type;

endpackage

>>> design/sorted_voxel_table_neighbour_query_unit.sv
// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_stall  action, x_coord, y_coord, z_coord
// rsp_*     out        rsp_valid / rsp_stall  present, sides_mask, status
//
// One request at a time; each search step uses the single table read port and comparator
// for a read and then a compare: check runs one binary search, a sides query up to seven
// searches, and insert moves the entries above the slot one at a time, then places the key.
// Reset clears the entry count and control state only; table contents are not cleared.
// The result register lets a new request start while rsp_stall holds the previous result.
module sorted_voxel_table_neighbour_query_unit
   import svq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [COORD_BITS-1:0] req_x_coord,
   input  logic [COORD_BITS-1:0] req_y_coord,
   input  logic [COORD_BITS-1:0] req_z_coord,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_present,
   output logic [MASK_W-1:0]     rsp_sides_mask,
   output logic                  rsp_status
);

   localparam int CODE_W = 3 * COORD_BITS;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = $clog2(TABLE_DEPTH);

   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic [COORD_BITS-1:0] z_ff, z_in;
   step_type              step_ff, step_in;
   logic [CODE_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      shift_ff, shift_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  present_ff, present_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic                  status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_present_ff, rsp_present_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [CODE_W-1:0] gen_key;
   logic              gen_in_range;
   logic [CNT_W-1:0]  mid_calc;
   logic [CNT_W-1:0]  shift_dec;
   logic              rsp_free;
   logic              key_lt;
   logic              key_eq;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [CODE_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [CODE_W-1:0] rd_data;

   svq_key_gen #(
      .COORD_BITS (COORD_BITS)
   ) u_key_gen (
      .x_coord  (x_ff),
      .y_coord  (y_ff),
      .z_coord  (z_ff),
      .step     (step_ff),
      .key      (gen_key),
      .in_range (gen_in_range)
   );

   svq_code_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (CODE_W)
   ) u_code_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign shift_dec = shift_ff - CNT_ONE;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign key_lt    = (rd_data < key_ff);
   assign key_eq    = (rd_data == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      step_ff        <= step_in;
      key_ff         <= key_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      found_ff       <= found_in;
      shift_ff       <= shift_in;
      present_ff     <= present_in;
      mask_ff        <= mask_in;
      status_ff      <= status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      step_in        = step_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      found_in       = found_ff;
      shift_in       = shift_ff;
      count_in       = count_ff;
      present_in     = present_ff;
      mask_in        = mask_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_status_in  = rsp_status_ff;
      req_stall      = 1'b1;
      wr_en          = 1'b0;
      wr_addr        = shift_ff[IDX_W-1:0];
      wr_data        = rd_data;
      rd_addr        = mid_calc[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               action_in  = req_action;
               x_in       = req_x_coord;
               y_in       = req_y_coord;
               z_in       = req_z_coord;
               step_in    = STEP_CENTER;
               present_in = 1'b0;
               status_in  = 1'b0;
               mask_in    = (req_action == ACT_SIDES) ? '1 : '0;
               if (req_action == ACT_INSERT || req_action == ACT_CHECK ||
                   req_action == ACT_SIDES) begin
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_KEY: begin
            if (gen_in_range) begin
               key_in   = gen_key;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               state_in = ST_PROBE;
            end else if (step_ff == STEP_Y_DOWN) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end

         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid_calc[IDX_W-1:0];
               mid_in   = mid_calc;
               state_in = ST_COMPARE;
            end else if (step_ff == STEP_CENTER) begin
               present_in = found_ff;
               if (action_ff == ACT_INSERT) begin
                  if (found_ff) begin
                     state_in = ST_FINISH;
                  end else if (count_ff == CNT_FULL) begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end else begin
                     shift_in = count_ff;
                     state_in = ST_SHIFT_RD;
                  end
               end else if (action_ff == ACT_SIDES) begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               if (found_ff) begin
                  mask_in[3'(step_ff - STEP_W'(1))] = 1'b0;
               end
               if (step_ff == STEP_Y_DOWN) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = ST_KEY;
               end
            end
         end

         ST_COMPARE: begin
            found_in = found_ff || key_eq;
            if (key_lt) begin
               lo_in = mid_ff + CNT_ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_PROBE;
         end

         ST_SHIFT_RD: begin
            rd_addr = shift_dec[IDX_W-1:0];
            if (shift_ff == lo_ff) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = shift_ff[IDX_W-1:0];
            wr_data  = rd_data;
            shift_in = shift_dec;
            state_in = ST_SHIFT_RD;
         end

         ST_PLACE: begin
            wr_en      = 1'b1;
            wr_addr    = lo_ff[IDX_W-1:0];
            wr_data    = key_ff;
            count_in   = count_ff + CNT_ONE;
            present_in = 1'b1;
            state_in   = ST_FINISH;
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = present_ff;
               rsp_mask_in    = mask_ff;
               rsp_status_in  = status_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_sides_mask = rsp_mask_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> design/svq_code_mem.sv
module svq_code_mem
   import svq_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int WIDTH = 3 * COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/svq_key_gen.sv
module svq_key_gen
   import svq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]   x_coord,
   input  logic [COORD_BITS-1:0]   y_coord,
   input  logic [COORD_BITS-1:0]   z_coord,
   input  step_type                step,
   output logic [3*COORD_BITS-1:0] key,
   output logic                    in_range
);

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
   localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

   logic [COORD_BITS-1:0] nx;
   logic [COORD_BITS-1:0] ny;
   logic [COORD_BITS-1:0] nz;

   always_comb begin
      nx       = x_coord;
      ny       = y_coord;
      nz       = z_coord;
      in_range = 1'b1;
      unique case (step)
         STEP_CENTER: begin
         end
         STEP_Y_UP: begin
            in_range = (y_coord != COORD_MAX);
            ny       = y_coord + COORD_ONE;
         end
         STEP_Z_UP: begin
            in_range = (z_coord != COORD_MAX);
            nz       = z_coord + COORD_ONE;
         end
         STEP_X_UP: begin
            in_range = (x_coord != COORD_MAX);
            nx       = x_coord + COORD_ONE;
         end
         STEP_X_DOWN: begin
            in_range = (x_coord != '0);
            nx       = x_coord - COORD_ONE;
         end
         STEP_Z_DOWN: begin
            in_range = (z_coord != '0);
            nz       = z_coord - COORD_ONE;
         end
         STEP_Y_DOWN: begin
            in_range = (y_coord != '0);
            ny       = y_coord - COORD_ONE;
         end
         default: begin
            in_range = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < COORD_BITS; i++) begin
         key[3*i]   = nx[i];
         key[3*i+1] = ny[i];
         key[3*i+2] = nz[i];
      end
   end

endmodule

>>> tb/tb_sorted_voxel_table_neighbour_query_unit.sv
module tb_sorted_voxel_table_neighbour_query_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import svq_pkg::*;

   localparam int DEPTH  = TABLE_DEPTH_DEFAULT;
   localparam int CB     = COORD_BITS_DEFAULT;
   localparam int CODE_W = 3 * CB;
   localparam int CMAX   = (1 << CB) - 1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [CB-1:0] C_ZERO = '0;
   localparam logic [CB-1:0] C_ONE  = CB'(1);
   localparam logic [CB-1:0] C_TOP  = CB'(CMAX);

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [CB-1:0]       x;
      logic [CB-1:0]       y;
      logic [CB-1:0]       z;
      logic                present;
      logic [MASK_W-1:0]   sides;
      logic                status;
   } voxel_answer_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action     = ACT_INSERT;
   logic [CB-1:0]       req_x_coord    = '0;
   logic [CB-1:0]       req_y_coord    = '0;
   logic [CB-1:0]       req_z_coord    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic                rsp_present;
   logic [MASK_W-1:0]   rsp_sides_mask;
   logic                rsp_status;

   logic [CODE_W-1:0] held_codes[$];
   voxel_answer_type  expected_answers[$];
   voxel_answer_type  oldest;

   bit quiet       = 1'b0;
   bit hold_on     = 1'b0;
   int hold_left   = 0;
   int rsp_gap     = 0;
   int mismatches  = 0;
   int responses   = 0;
   int peak_fill   = 0;
   int sent_by_action[4];

   sorted_voxel_table_neighbour_query_unit #(
      .TABLE_DEPTH (DEPTH),
      .COORD_BITS  (CB)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_z_coord    (req_z_coord),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_present    (rsp_present),
      .rsp_sides_mask (rsp_sides_mask),
      .rsp_status     (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [CODE_W-1:0] voxel_code(input logic [CB-1:0] x, y, z);
      logic [CODE_W-1:0] c;
      c = '0;
      for (int i = 0; i < CB; i++) begin
         c[3*i]   = x[i];
         c[3*i+1] = y[i];
         c[3*i+2] = z[i];
      end
      return c;
   endfunction

   function automatic int code_slot(input logic [CODE_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = held_codes.size();
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (held_codes[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic bit code_held(input logic [CB-1:0] x, y, z);
      logic [CODE_W-1:0] key;
      int pos;
      key = voxel_code(x, y, z);
      pos = code_slot(key);
      return pos < held_codes.size() && held_codes[pos] == key;
   endfunction

   function automatic voxel_answer_type predict_request(input logic [ACTION_W-1:0] act,
                                                        input logic [CB-1:0] x, y, z);
      voxel_answer_type r;
      logic [CODE_W-1:0] key;
      int pos;
      r.action  = act;
      r.x       = x;
      r.y       = y;
      r.z       = z;
      r.present = 1'b0;
      r.sides   = '0;
      r.status  = 1'b0;
      key = voxel_code(x, y, z);
      case (act)
         ACT_INSERT: begin
            pos = code_slot(key);
            if (pos < held_codes.size() && held_codes[pos] == key) begin
               r.present = 1'b1;
            end else if (held_codes.size() >= DEPTH) begin
               r.status = 1'b1;
            end else begin
               held_codes.insert(pos, key);
               r.present = 1'b1;
            end
         end
         ACT_CHECK: r.present = code_held(x, y, z);
         ACT_SIDES: begin
            r.present = code_held(x, y, z);
            r.sides   = '1;
            if (y < CMAX && code_held(x, y + C_ONE, z)) r.sides[0] = 1'b0;
            if (z < CMAX && code_held(x, y, z + C_ONE)) r.sides[1] = 1'b0;
            if (x < CMAX && code_held(x + C_ONE, y, z)) r.sides[2] = 1'b0;
            if (x > 0 && code_held(x - C_ONE, y, z)) r.sides[3] = 1'b0;
            if (z > 0 && code_held(x, y, z - C_ONE)) r.sides[4] = 1'b0;
            if (y > 0 && code_held(x, y - C_ONE, z)) r.sides[5] = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int draw_base(input int span);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 0;
      if (r < 6) return CMAX - span + 1;
      return $urandom_range(0, CMAX - span + 1);
   endfunction

   function automatic logic [CB-1:0] draw_near(input int base, input int span);
      if ($urandom_range(0, 99) < 85) return CB'(base + $urandom_range(0, span - 1));
      return CB'($urandom_range(0, CMAX));
   endfunction

   function automatic logic [ACTION_W-1:0] draw_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return ACT_INSERT;
      if (r < 65) return ACT_CHECK;
      if (r < 95) return ACT_SIDES;
      return ACT_UNUSED;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 20) begin
         $display("mismatch at %0t: %s got %0d want %0d (action %0d at %0d,%0d,%0d)",
                  $realtime, what, got, want, oldest.action, oldest.x, oldest.y, oldest.z);
      end
      mismatches++;
   endtask

   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CB-1:0] x, y, z);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      expected_answers.insert(expected_answers.size(), predict_request(act, x, y, z));
      sent_by_action[act]++;
      if (held_codes.size() > peak_fill) peak_fill = held_codes.size();
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (expected_answers.size() == 0) begin
               oldest = '{default: '0};
               report_mismatch("result with no request pending", 1, 0);
            end else begin
               oldest = expected_answers.pop_front();
               if (rsp_present !== oldest.present)
                  report_mismatch("present", rsp_present, oldest.present);
               if (rsp_sides_mask !== oldest.sides)
                  report_mismatch("sides_mask", rsp_sides_mask, oldest.sides);
               if (rsp_status !== oldest.status)
                  report_mismatch("status", rsp_status, oldest.status);
            end
            rsp_gap = quiet ? 0 : $urandom_range(0, 13);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end
         rsp_stall <= (rsp_gap > 0) || hold_on;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_on <= 1'b1;
         hold_left--;
      end else begin
         hold_on <= 1'b0;
      end
   end

   task automatic test_directed();
      send_request(ACT_CHECK, C_ZERO, C_ZERO, C_ZERO);
      send_request(ACT_SIDES, C_ZERO, C_ZERO, C_ZERO);
      send_request(ACT_UNUSED, C_TOP, C_TOP, C_TOP);
      send_request(ACT_INSERT, C_ZERO, C_ZERO, C_ZERO);
      send_request(ACT_INSERT, C_ZERO, C_ZERO, C_ZERO);
      send_request(ACT_INSERT, C_ONE, C_ZERO, C_ZERO);
      send_request(ACT_INSERT, C_ZERO, C_ONE, C_ZERO);
      send_request(ACT_INSERT, C_ZERO, C_ZERO, C_ONE);
      send_request(ACT_SIDES, C_ZERO, C_ZERO, C_ZERO);
      send_request(ACT_SIDES, C_ONE, C_ZERO, C_ZERO);
      send_request(ACT_INSERT, C_TOP, C_TOP, C_TOP);
      send_request(ACT_SIDES, C_TOP, C_TOP, C_TOP);
      send_request(ACT_INSERT, C_TOP - C_ONE, C_TOP, C_TOP);
      send_request(ACT_INSERT, C_TOP, C_TOP - C_ONE, C_TOP);
      send_request(ACT_INSERT, C_TOP, C_TOP, C_TOP - C_ONE);
      send_request(ACT_SIDES, C_TOP, C_TOP, C_TOP);
      send_request(ACT_CHECK, C_TOP, C_TOP, C_TOP);
      send_request(ACT_INSERT, 10'h2AA, 10'h155, 10'h2AA);
      send_request(ACT_CHECK, 10'h2AA, 10'h155, 10'h2AA);
      send_request(ACT_CHECK, 10'h155, 10'h2AA, 10'h155);
      send_request(ACT_SIDES, 10'h2AA, 10'h156, 10'h2AA);
      send_request(ACT_UNUSED, C_ZERO, C_ZERO, C_ZERO);
   endtask

   task automatic test_random_mix(input int batches, input int per_batch);
      int bx, by, bz, span;
      for (int b = 0; b < batches; b++) begin
         quiet = (b % 6 == 5);
         span  = $urandom_range(2, 5);
         bx    = draw_base(span);
         by    = draw_base(span);
         bz    = draw_base(span);
         repeat (per_batch) begin
            send_request(draw_action(), draw_near(bx, span), draw_near(by, span),
                         draw_near(bz, span));
         end
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      int bx, by, bz;
      bx        = draw_base(4);
      by        = draw_base(4);
      bz        = draw_base(4);
      quiet     = 1'b1;
      hold_left = 400;
      repeat (40) begin
         send_request(ACTION_W'($urandom_range(0, 2)), draw_near(bx, 4), draw_near(by, 4),
                      draw_near(bz, 4));
      end
      quiet = 1'b0;
   endtask

   task automatic test_full_table();
      logic [CODE_W-1:0] c;
      logic [CB-1:0] x, y, z;
      // fill from the top corner block so new codes land near the end of the table
      c     = {CODE_W{1'b1}} - CODE_W'(DEPTH - 1);
      quiet = 1'b1;
      while (held_codes.size() < DEPTH) begin
         for (int i = 0; i < CB; i++) begin
            x[i] = c[3*i];
            y[i] = c[3*i+1];
            z[i] = c[3*i+2];
         end
         send_request(ACT_INSERT, x, y, z);
         c++;
      end
      quiet = 1'b0;
      repeat (3) begin
         do begin
            x = CB'($urandom_range(0, CMAX));
            y = CB'($urandom_range(0, CMAX));
            z = CB'($urandom_range(0, CMAX));
         end while (code_held(x, y, z));
         send_request(ACT_INSERT, x, y, z);
         send_request(ACT_CHECK, x, y, z);
      end
      send_request(ACT_INSERT, C_TOP, C_TOP, C_TOP);
      send_request(ACT_SIDES, C_TOP, C_TOP, C_TOP);
      send_request(ACT_SIDES, C_TOP - CB'(15), C_TOP - CB'(7), C_TOP - CB'(7));
      send_request(ACT_UNUSED, C_TOP, C_ZERO, C_TOP);
      repeat (30) begin
         send_request(draw_action(), draw_near(CMAX - 19, 20), draw_near(CMAX - 9, 10),
                      draw_near(CMAX - 9, 10));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(13, 50);
      test_backpressure();
      test_random_mix(13, 50);
      test_full_table();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d inserts, %0d checks, %0d sides queries, %0d unused-action requests",
               sent_by_action[ACT_INSERT], sent_by_action[ACT_CHECK],
               sent_by_action[ACT_SIDES], sent_by_action[ACT_UNUSED]);
      $display("%0d results checked, table filled to %0d of %0d entries, %0d mismatches",
               responses, peak_fill, DEPTH, mismatches);
      if (mismatches == 0) begin
         $display("[sorted_voxel_table_neighbour_query_unit] OK");
      end else begin
         $display("[sorted_voxel_table_neighbour_query_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("timeout with %0d results outstanding", expected_answers.size());
      $display("[sorted_voxel_table_neighbour_query_unit] ERROR");
      $finish;
   end

endmodule

>>> files.f
design/svq_pkg.sv
design/svq_code_mem.sv
design/svq_key_gen.sv
design/sorted_voxel_table_neighbour_query_unit.sv
tb/tb_sorted_voxel_table_neighbour_query_unit.sv
